// ----- rtl/bspf_pkg.sv -----
// Shared types, constants and helpers of the byte-stuffed packet framer.
`timescale 1ns / 1ps
package bspf_pkg;

    localparam int BYTE_W     = 8;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 4;
    localparam int JOBQ_DEPTH = 2;
    localparam int NUM_SLOTS  = 8;

    localparam logic [BYTE_W-1:0] CHECK_MOD     = 8'd255;
    localparam logic [BYTE_W-1:0] COUNT_LAST    = 8'd254;
    localparam logic [BYTE_W-1:0] RST_START     = 8'd2;
    localparam logic [BYTE_W-1:0] RST_END       = 8'd3;
    localparam logic [BYTE_W-1:0] RST_QUOTE     = 8'd16;

    localparam logic [1:0] REG_START = 2'd0;
    localparam logic [1:0] REG_END   = 2'd1;
    localparam logic [1:0] REG_QUOTE = 2'd2;

    // Output slot positions of one request, in line order.
    localparam int SLOT_START = 0;
    localparam int SLOT_CNT_Q = 1;
    localparam int SLOT_CNT   = 2;
    localparam int SLOT_PAY_Q = 3;
    localparam int SLOT_PAY   = 4;
    localparam int SLOT_SUM_Q = 5;
    localparam int SLOT_SUM   = 6;
    localparam int SLOT_END   = 7;

    typedef logic [BYTE_W-1:0]    t_byte;
    typedef logic [NUM_SLOTS-1:0] t_slots;

    typedef struct packed {
        t_byte start_byte;
        t_byte end_byte;
        t_byte quote_byte;
    } t_cfg;

    typedef struct packed {
        t_slots mask;
        t_byte  pay;
        t_byte  cnt;
        t_byte  sum;
    } t_job;

    function automatic logic is_reserved(t_byte b, t_cfg c);
        is_reserved = (b == c.start_byte) || (b == c.end_byte) || (b == c.quote_byte);
    endfunction

endpackage

// ----- rtl/bspf_front.sv -----
// Front end: accepts packet bytes, keeps check sum and packet counter, builds jobs.
`timescale 1ns / 1ps
module bspf_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_accept,
    input  bspf_pkg::t_byte i_payload_byte,
    input  logic           i_first_in,
    input  logic           i_last_in,
    input  bspf_pkg::t_cfg i_cfg,
    output bspf_pkg::t_job o_job
);
    import bspf_pkg::*;

    t_byte         r_sum, n_sum;
    t_byte         r_cnt, n_cnt;
    t_byte         sum_base;
    logic [BYTE_W:0] sum_wide;
    t_slots        mask;

    assign sum_base = i_first_in ? '0 : r_sum;
    assign sum_wide = {1'b0, sum_base} + {1'b0, i_payload_byte};

    always_comb begin
        if (sum_wide >= {1'b0, CHECK_MOD}) begin
            n_sum = BYTE_W'(sum_wide - {1'b0, CHECK_MOD});
        end else begin
            n_sum = sum_wide[BYTE_W-1:0];
        end
        n_cnt = r_cnt;
        if (i_last_in) begin
            n_cnt = (r_cnt == COUNT_LAST) ? '0 : r_cnt + 1'b1;
        end
    end

    always_comb begin
        mask             = '0;
        mask[SLOT_START] = i_first_in;
        mask[SLOT_CNT_Q] = i_first_in & is_reserved(r_cnt, i_cfg);
        mask[SLOT_CNT]   = i_first_in;
        mask[SLOT_PAY_Q] = is_reserved(i_payload_byte, i_cfg);
        mask[SLOT_PAY]   = 1'b1;
        mask[SLOT_SUM_Q] = i_last_in & is_reserved(n_sum, i_cfg);
        mask[SLOT_SUM]   = i_last_in;
        mask[SLOT_END]   = i_last_in;
    end

    assign o_job = '{mask: mask, pay: i_payload_byte, cnt: r_cnt, sum: n_sum};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
            r_cnt <= '0;
        end else if (i_accept) begin
            r_sum <= n_sum;
            r_cnt <= n_cnt;
        end
    end

    a_sum_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sum != CHECK_MOD) else $error("check sum left its modulo range");
    a_cnt_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && !i_last_in) |=> $stable(r_cnt))
        else $error("packet counter moved without a last byte");

endmodule

// ----- rtl/bspf_jobq.sv -----
// Short job queue between the front end and the line sequencer.
`timescale 1ns / 1ps
module bspf_jobq #(
    parameter int P_DEPTH = bspf_pkg::JOBQ_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_wr,
    input  bspf_pkg::t_job i_job,
    output logic           o_full,
    input  logic           i_rd,
    output logic           o_valid,
    output bspf_pkg::t_job o_job
);
    import bspf_pkg::*;

    localparam int PTR_W = (P_DEPTH > 1) ? $clog2(P_DEPTH) : 1;
    localparam int CNT_W = $clog2(P_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(P_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(P_DEPTH);

    t_job             r_mem [P_DEPTH];
    logic [PTR_W-1:0] r_wptr, r_rptr;
    logic [CNT_W-1:0] r_cnt;
    logic             wr_en, rd_en;

    assign o_full  = (r_cnt == CNT_FULL);
    assign o_valid = (r_cnt != '0);
    assign o_job   = r_mem[r_rptr];
    assign wr_en   = i_wr & ~o_full;
    assign rd_en   = i_rd & o_valid;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (wr_en) begin
                r_wptr <= (r_wptr == PTR_LAST) ? '0 : r_wptr + 1'b1;
            end
            if (rd_en) begin
                r_rptr <= (r_rptr == PTR_LAST) ? '0 : r_rptr + 1'b1;
            end
            if (wr_en && !rd_en) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (rd_en && !wr_en) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_FULL) else $error("job queue count overflow");

endmodule

// ----- rtl/bspf_back.sv -----
// Line sequencer: walks the slots of the head job and emits one line byte per cycle while pop stays high.
`timescale 1ns / 1ps
module bspf_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  bspf_pkg::t_cfg i_cfg,
    input  logic           i_head_valid,
    input  bspf_pkg::t_job i_head,
    output logic           o_head_done,
    input  logic           i_pop,
    output logic           o_empty,
    output bspf_pkg::t_byte o_line_byte,
    output logic           o_run_end
);
    import bspf_pkg::*;

    t_slots r_sent, n_sent;
    logic   r_ovalid;
    t_byte  r_obyte;
    logic   r_oend;
    t_slots remain;
    t_slots pick;
    logic   advance;
    logic   last_slot;
    t_byte  sel_byte;

    assign remain    = i_head.mask & ~r_sent;
    assign pick      = remain & (~remain + 1'b1);
    assign last_slot = (remain == pick);
    assign advance   = i_head_valid & (~r_ovalid | i_pop);
    assign o_head_done = advance & last_slot;

    always_comb begin
        priority if (pick[SLOT_START]) begin
            sel_byte = i_cfg.start_byte;
        end else if (pick[SLOT_CNT_Q] || pick[SLOT_PAY_Q] || pick[SLOT_SUM_Q]) begin
            sel_byte = i_cfg.quote_byte;
        end else if (pick[SLOT_CNT]) begin
            sel_byte = i_head.cnt;
        end else if (pick[SLOT_PAY]) begin
            sel_byte = i_head.pay;
        end else if (pick[SLOT_SUM]) begin
            sel_byte = i_head.sum;
        end else begin
            sel_byte = i_cfg.end_byte;
        end
    end

    always_comb begin
        n_sent = r_sent;
        if (advance) begin
            n_sent = last_slot ? '0 : (r_sent | pick);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sent   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_sent <= n_sent;
            if (advance) begin
                r_ovalid <= 1'b1;
            end else if (i_pop) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_obyte <= sel_byte;
            r_oend  <= last_slot;
        end
    end

    assign o_empty     = ~r_ovalid;
    assign o_line_byte = r_obyte;
    assign o_run_end   = r_oend;

    a_sent_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_head_valid |-> (r_sent == '0)) else $error("slots marked without a job");
    a_sent_sub: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_head_valid |-> ((r_sent & ~i_head.mask) == '0))
        else $error("sent slot outside job mask");

endmodule

// ----- rtl/byte_stuffed_packet_framer_unit.sv -----
// Top level of the byte-stuffed packet framer: config registers and unit wiring.
`timescale 1ns / 1ps
// Usage:
//   Input queue side: drive i_payload_byte, i_first_in, i_last_in with push;
//   a request is taken on a clock edge with push high and full low.
//   Output queue side: while empty is low, o_line_byte and o_run_end show the
//   oldest line byte; pop high at a clock edge takes it. o_run_end marks the
//   last line byte caused by one request.
//   Each request yields 1 to 8 line bytes: start byte and stuffed counter on a
//   first byte, the stuffed payload byte, stuffed check byte and end byte on a
//   last byte. The line sequencer emits one byte per cycle while pop stays high;
//   a request's first line byte passes the job queue and then the output register.
//   A two-entry job queue decouples the front end, so requests keep flowing
//   while the sequencer works. When pop stays low, the output register holds,
//   the job queue fills and full rises.
//   Config: APB port, start byte at 0x0, end byte at 0x4, quote byte at 0x8;
//   write only while the block is idle.
//   Reset (synchronous, active low) restores 0x02 / 0x03 / 0x10, clears check
//   sum, packet counter, queue and output register.
module byte_stuffed_packet_framer_unit #(
    parameter int P_JOBQ_DEPTH = bspf_pkg::JOBQ_DEPTH
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                push,
    output logic                                full,
    input  bspf_pkg::t_byte                     i_payload_byte,
    input  logic                                i_first_in,
    input  logic                                i_last_in,
    output logic                                empty,
    input  logic                                pop,
    output bspf_pkg::t_byte                     o_line_byte,
    output logic                                o_run_end,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [bspf_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [bspf_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [bspf_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);
    import bspf_pkg::*;

    t_cfg   r_cfg;
    t_job   front_job, head_job;
    logic   q_full, head_valid, head_done, in_accept, cfg_wr;
    logic [1:0] reg_idx;

    assign pready    = 1'b1;
    assign reg_idx   = paddr[3:2];
    assign cfg_wr    = psel & penable & pwrite;
    assign full      = q_full;
    assign in_accept = push & ~q_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_byte <= RST_START;
            r_cfg.end_byte   <= RST_END;
            r_cfg.quote_byte <= RST_QUOTE;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_START: r_cfg.start_byte <= pwdata[BYTE_W-1:0];
                REG_END:   r_cfg.end_byte   <= pwdata[BYTE_W-1:0];
                REG_QUOTE: r_cfg.quote_byte <= pwdata[BYTE_W-1:0];
                default:   ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_START: prdata = APB_DATA_W'(r_cfg.start_byte);
            REG_END:   prdata = APB_DATA_W'(r_cfg.end_byte);
            REG_QUOTE: prdata = APB_DATA_W'(r_cfg.quote_byte);
            default:   prdata = '0;
        endcase
    end

    bspf_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (in_accept),
        .i_payload_byte (i_payload_byte),
        .i_first_in     (i_first_in),
        .i_last_in      (i_last_in),
        .i_cfg          (r_cfg),
        .o_job          (front_job)
    );

    bspf_jobq #(
        .P_DEPTH (P_JOBQ_DEPTH)
    ) u_jobq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (push),
        .i_job   (front_job),
        .o_full  (q_full),
        .i_rd    (head_done),
        .o_valid (head_valid),
        .o_job   (head_job)
    );

    bspf_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_head_valid (head_valid),
        .i_head       (head_job),
        .o_head_done  (head_done),
        .i_pop        (pop),
        .o_empty      (empty),
        .o_line_byte  (o_line_byte),
        .o_run_end    (o_run_end)
    );

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps
// Testbench for the byte-stuffed packet framer: request driver, line monitor and frame predictor.
module tb_top;
    import bspf_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int LONG_HOLD      = 300;
    localparam int DRAIN_CYCLES   = 12;
    localparam int WRAP_LASTS     = 256;

    typedef struct packed {
        t_byte data;
        logic  first_mark;
        logic  last_mark;
    } t_req;

    typedef struct packed {
        t_byte data;
        logic  run_end;
    } t_line;

    typedef enum int {FLAW_NONE, FLAW_NO_FIRST, FLAW_NO_LAST, FLAW_REOPEN} t_flaw;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  push = 1'b0;
    logic                  full;
    t_byte                 i_payload_byte = '0;
    logic                  i_first_in = 1'b0;
    logic                  i_last_in = 1'b0;
    logic                  empty;
    logic                  pop = 1'b0;
    t_byte                 o_line_byte;
    logic                  o_run_end;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    byte_stuffed_packet_framer_unit dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_payload_byte (i_payload_byte),
        .i_first_in     (i_first_in),
        .i_last_in      (i_last_in),
        .empty          (empty),
        .pop            (pop),
        .o_line_byte    (o_line_byte),
        .o_run_end      (o_run_end),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    t_req  pending_requests[$];
    t_line expected_line[$];
    t_req  next_req;
    t_byte reg_val [3] = '{RST_START, RST_END, RST_QUOTE};
    t_byte run_sum = '0;
    t_byte pkt_count = '0;

    int    err_cnt = 0;
    int    requests_taken = 0;
    int    lines_seen = 0;
    int    frames_closed = 0;
    int    counter_wraps = 0;
    int    settings_used = 0;
    int    lasts_queued = 0;
    int    idle_cycles = 0;
    int    hold_orders = 0;
    int    holds_done = 0;
    int    hold_left = 0;
    int    send_gap = 0;
    int    recv_gap = 0;
    logic  in_taken = 1'b0;
    logic  idle_on = 1'b1;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic void push_line(t_byte b);
        expected_line.push_back('{b, 1'b0});
    endfunction

    function automatic void push_stuffed(t_byte b);
        if (b == reg_val[REG_START] || b == reg_val[REG_END] || b == reg_val[REG_QUOTE])
            push_line(reg_val[REG_QUOTE]);
        push_line(b);
    endfunction

    function automatic void frame_request(t_byte b, logic first_mark, logic last_mark);
        t_line tail;
        if (first_mark) begin
            run_sum = '0;
            push_line(reg_val[REG_START]);
            push_stuffed(pkt_count);
        end
        push_stuffed(b);
        run_sum = t_byte'((int'(run_sum) + int'(b)) % int'(CHECK_MOD));
        if (last_mark) begin
            push_stuffed(run_sum);
            push_line(reg_val[REG_END]);
            frames_closed++;
            if (pkt_count == COUNT_LAST) begin
                pkt_count = '0;
                counter_wraps++;
            end else begin
                pkt_count = pkt_count + 8'd1;
            end
        end
        tail = expected_line.pop_back();
        tail.run_end = 1'b1;
        expected_line.push_back(tail);
    endfunction

    function automatic t_byte pick_byte();
        case ($urandom_range(0, 7))
            0, 1: return reg_val[$urandom_range(0, 2)];
            2: return 8'h00;
            3: return 8'hFF;
            default: return t_byte'($urandom);
        endcase
    endfunction

    function automatic void queue_request(t_byte b, logic first_mark, logic last_mark);
        pending_requests.push_back('{b, first_mark, last_mark});
        if (last_mark)
            lasts_queued++;
    endfunction

    // mostly well-formed packets, some with a missing or repeated mark
    task automatic queue_random(input int n_items, input int multi_pct);
        int    made;
        int    len;
        t_flaw flaw;
        made = 0;
        while (made < n_items) begin
            len = ($urandom_range(1, 100) <= multi_pct) ? $urandom_range(2, 8) : 1;
            flaw = FLAW_NONE;
            if ($urandom_range(0, 5) == 0)
                flaw = t_flaw'($urandom_range(1, 3));
            if (flaw == FLAW_REOPEN && len < 3)
                len = 3;
            for (int k = 0; k < len; k++) begin
                queue_request(pick_byte(),
                              (k == 0 && flaw != FLAW_NO_FIRST) ||
                              (flaw == FLAW_REOPEN && k == len / 2),
                              k == len - 1 && flaw != FLAW_NO_LAST);
            end
            made += len;
        end
    endtask

    task automatic apb_write(input logic [1:0] idx, input t_byte val);
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= APB_ADDR_W'({idx, 2'b00});
        pwdata <= APB_DATA_W'(val);
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        reg_val[idx] = val;
    endtask

    task automatic apply_regs(input t_byte start_v, input t_byte end_v, input t_byte quote_v);
        apb_write(REG_START, start_v);
        apb_write(REG_END, end_v);
        apb_write(REG_QUOTE, quote_v);
        settings_used++;
    endtask

    task automatic wait_drained();
        do @(posedge i_clk);
        while (pending_requests.size() != 0 || push || expected_line.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // request driver
    always @(negedge i_clk) begin
        if (!push || in_taken) begin
            if (send_gap > 0) begin
                send_gap <= send_gap - 1;
                push <= 1'b0;
            end else if (pending_requests.size() > 0) begin
                next_req = pending_requests.pop_front();
                push <= 1'b1;
                i_payload_byte <= next_req.data;
                i_first_in <= next_req.first_mark;
                i_last_in <= next_req.last_mark;
                if (idle_on && $urandom_range(0, 9) == 0)
                    send_gap <= $urandom_range(1, 14);
            end else begin
                push <= 1'b0;
            end
        end
    end

    // line receiver
    always @(negedge i_clk) begin
        if (holds_done != hold_orders) begin
            holds_done <= hold_orders;
            hold_left <= LONG_HOLD;
            pop <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            pop <= 1'b0;
        end else if (recv_gap > 0) begin
            recv_gap <= recv_gap - 1;
            pop <= 1'b0;
        end else begin
            pop <= i_rst_n;
            if (idle_on && $urandom_range(0, 7) == 0)
                recv_gap <= $urandom_range(1, 14);
        end
    end

    // monitor: check line bytes, predict accepted requests
    always @(posedge i_clk) begin
        t_line want;
        if (i_rst_n) begin
            if (pop && !empty) begin
                if (expected_line.size() == 0) begin
                    $error("unexpected line byte %02h, run_end %0b", o_line_byte, o_run_end);
                    err_cnt++;
                end else begin
                    want = expected_line.pop_front();
                    if (o_line_byte !== want.data) begin
                        $error("line_byte mismatch: expected %02h, actual %02h",
                               want.data, o_line_byte);
                        err_cnt++;
                    end
                    if (o_run_end !== want.run_end) begin
                        $error("run_end mismatch: expected %0b, actual %0b",
                               want.run_end, o_run_end);
                        err_cnt++;
                    end
                end
                lines_seen++;
            end
            if (push && !full) begin
                frame_request(i_payload_byte, i_first_in, i_last_in);
                requests_taken++;
            end
        end
        in_taken <= i_rst_n && push && !full;
        idle_cycles <= ((pop && !empty) || (push && !full)) ? 0 : idle_cycles + 1;
    end

    initial begin
        while (idle_cycles < WATCHDOG_LIMIT)
            @(posedge i_clk);
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        i_rst_n = 1'b0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        queue_request(8'h00, 1'b1, 1'b1);
        queue_request(8'hFF, 1'b1, 1'b1);
        queue_request(8'h02, 1'b1, 1'b0);
        queue_request(8'h03, 1'b0, 1'b0);
        queue_request(8'h10, 1'b0, 1'b0);
        queue_request(8'hFE, 1'b0, 1'b0);
        queue_request(8'hFF, 1'b0, 1'b1);
        queue_request(8'h02, 1'b1, 1'b1);
        // reopen a frame before it closes
        queue_request(8'h11, 1'b1, 1'b0);
        queue_request(8'h22, 1'b0, 1'b0);
        queue_request(8'h33, 1'b1, 1'b0);
        queue_request(8'h44, 1'b0, 1'b1);
        // bytes outside a frame, then a close without an open
        queue_request(8'h10, 1'b0, 1'b0);
        queue_request(8'h80, 1'b0, 1'b1);
        // check byte landing on a reserved value
        queue_request(8'h01, 1'b1, 1'b0);
        queue_request(8'h01, 1'b0, 1'b1);
        queue_request(8'hFF, 1'b1, 1'b0);
        queue_request(8'hFF, 1'b0, 1'b0);
        queue_request(8'h02, 1'b0, 1'b1);
        queue_request(8'h10, 1'b1, 1'b1);
        wait_drained();

        apply_regs(8'h00, 8'hFF, 8'h80);
        queue_random(16, 70);
        wait_drained();

        apply_regs(8'h55, 8'h55, 8'h55);
        hold_orders++;
        queue_random(20, 70);
        wait_drained();

        apply_regs(8'hFF, 8'h00, 8'h7E);
        queue_random(16, 70);
        wait_drained();

        apply_regs(t_byte'($urandom), t_byte'($urandom), t_byte'($urandom));
        queue_random(16, 70);
        wait_drained();

        idle_on = 1'b0;
        apply_regs(RST_START, RST_END, RST_QUOTE);
        // single-byte frames until the packet counter wraps
        while (lasts_queued < WRAP_LASTS)
            queue_request(pick_byte(), 1'b1, 1'b1);
        wait_drained();

        $display("Run: %0d requests framed into %0d line bytes over %0d register settings.",
                 requests_taken, lines_seen, settings_used + 1);
        $display("Frames closed: %0d, packet counter wraps: %0d, output hold-offs: %0d.",
                 frames_closed, counter_wraps, hold_orders);
        if (err_cnt == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
